>>> rtl/gmi_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the grib message indexer
package gmi_pkg;

  localparam int OFFSET_BITS_DEF = 40;
  localparam int LENGTH_BITS_DEF = 32;

  localparam int OFFSET_W = 40;
  localparam int LENGTH_W = 32;
  localparam int INDEX_W  = 16;

  localparam logic [31:0] MARK_GRIB = 32'h4752_4942;
  localparam logic [31:0] MARK_END  = 32'h3737_3737;

  localparam logic [7:0] EDITION_ONE = 8'd1;

  // header byte positions within a message
  localparam logic [3:0] HIDX_FIRST   = 4'd4;
  localparam logic [3:0] HIDX_LEN_END = 4'd6;
  localparam logic [3:0] HIDX_EDITION = 4'd7;
  localparam logic [3:0] HIDX_LAST    = 4'd15;

  // header bytes consumed and shortest legal message per length form
  localparam int HDR_ED1     = 8;
  localparam int HDR_EDN     = 16;
  localparam int TRAILER_LEN = 4;

  localparam logic RESULT_FOUND = 1'b0;
  localparam logic RESULT_ERROR = 1'b1;

  localparam logic [15:0] MAX_MESSAGES_RST = 16'hFFFF;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_BODY   = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                result_kind;
    logic [OFFSET_W-1:0] message_offset;
    logic [LENGTH_W-1:0] message_length;
    logic [7:0]          edition;
    logic [INDEX_W-1:0]  message_index;
  } out_item_t;

  typedef struct packed {
    logic      vld;
    out_item_t data;
  } scan_res_t;

  typedef struct packed {
    logic halted;
  } scan_stat_t;

endpackage

>>> rtl/gmi_scan.sv
`timescale 1ns / 1ps
// byte-at-a-time marker hunt, header decode and body/trailer check
module gmi_scan #(
  parameter int OFFSET_BITS = gmi_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = gmi_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic                item_vld,
  input  gmi_pkg::in_item_t   item,
  output gmi_pkg::scan_res_t  res,
  output gmi_pkg::scan_stat_t stat
);

  // accumulator keeps at least the 32 bits that are reported
  localparam int ACC_W = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

  gmi_pkg::phase_t         phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0]  pos_r, pos_nxt;
  logic [31:0]             recent_r, recent_nxt;
  logic [3:0]              hidx_r, hidx_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [7:0]              ed_r, ed_nxt;
  logic [OFFSET_BITS-1:0]  start_r, start_nxt;
  logic [LENGTH_BITS-1:0]  rem_r, rem_nxt;
  logic [15:0]             mf_r, mf_nxt;
  logic [ACC_W-1:0]        len_r, len_nxt;
  logic [15:0]             max_r;

  logic [ACC_W-1:0]        acc_sh;
  logic                    ovf_sh;
  logic [ACC_W-1:0]        take_len;
  logic                    take_ovf;
  logic [ACC_W-1:0]        take_min;
  logic [ACC_W-1:0]        take_hdr;
  logic                    take_bad;
  logic                    took;
  logic                    emit;
  logic                    kind;
  logic [7:0]              b;
  logic                    last;

  assign b    = item.data_byte;
  assign last = item.last_byte;

  assign acc_sh = {acc_r[ACC_W-9:0], b};
  assign ovf_sh = ovf_r | (|acc_r[ACC_W-1 -: 8]);

  // length is taken either right at the edition byte or at the last header byte
  always_comb begin
    if (hidx_r == gmi_pkg::HIDX_EDITION) begin
      take_len = acc_r;
      take_ovf = ovf_r;
      take_min = ACC_W'(gmi_pkg::HDR_ED1 + gmi_pkg::TRAILER_LEN);
      take_hdr = ACC_W'(gmi_pkg::HDR_ED1);
    end else begin
      take_len = acc_sh;
      take_ovf = ovf_sh;
      take_min = ACC_W'(gmi_pkg::HDR_EDN + gmi_pkg::TRAILER_LEN);
      take_hdr = ACC_W'(gmi_pkg::HDR_EDN);
    end
    take_bad = take_ovf | (|(take_len >> LENGTH_BITS)) | (take_len < take_min);
  end

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    recent_nxt = recent_r;
    hidx_nxt   = hidx_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    ed_nxt     = ed_r;
    start_nxt  = start_r;
    rem_nxt    = rem_r;
    mf_nxt     = mf_r;
    len_nxt    = len_r;
    emit       = 1'b0;
    kind       = gmi_pkg::RESULT_FOUND;
    took       = 1'b0;

    if (item_vld && phase_r != gmi_pkg::PH_STOP) begin
      pos_nxt    = pos_r + OFFSET_BITS'(1);
      recent_nxt = {recent_r[23:0], b};
      case (phase_r)
        gmi_pkg::PH_HUNT: begin
          if (recent_nxt == gmi_pkg::MARK_GRIB) begin
            start_nxt = pos_r - OFFSET_BITS'(3);
            hidx_nxt  = gmi_pkg::HIDX_FIRST;
            acc_nxt   = '0;
            ovf_nxt   = 1'b0;
            ed_nxt    = '0;
            len_nxt   = '0;
            phase_nxt = gmi_pkg::PH_HEADER;
            if (last) begin
              emit      = 1'b1;
              kind      = gmi_pkg::RESULT_ERROR;
              phase_nxt = gmi_pkg::PH_STOP;
            end
          end else if (last) begin
            phase_nxt = gmi_pkg::PH_STOP;
          end
        end
        gmi_pkg::PH_HEADER: begin
          hidx_nxt = hidx_r + 4'd1;
          if (hidx_r inside {[gmi_pkg::HIDX_FIRST:gmi_pkg::HIDX_LEN_END]}) begin
            acc_nxt = acc_sh;
            ovf_nxt = ovf_sh;
          end else if (hidx_r == gmi_pkg::HIDX_EDITION) begin
            ed_nxt = b;
            if (b == gmi_pkg::EDITION_ONE) begin
              took = 1'b1;
            end else begin
              acc_nxt = '0;
              ovf_nxt = 1'b0;
            end
          end else begin
            acc_nxt = acc_sh;
            ovf_nxt = ovf_sh;
            if (hidx_r == gmi_pkg::HIDX_LAST) begin
              took = 1'b1;
            end
          end
          if (took) begin
            len_nxt = take_len;
            rem_nxt = LENGTH_BITS'(take_len - take_hdr);
            if (take_bad || last) begin
              emit      = 1'b1;
              kind      = gmi_pkg::RESULT_ERROR;
              phase_nxt = gmi_pkg::PH_STOP;
            end else begin
              phase_nxt = gmi_pkg::PH_BODY;
            end
          end else if (last) begin
            emit      = 1'b1;
            kind      = gmi_pkg::RESULT_ERROR;
            phase_nxt = gmi_pkg::PH_STOP;
          end
        end
        gmi_pkg::PH_BODY: begin
          rem_nxt = rem_r - LENGTH_BITS'(1);
          if (rem_nxt != '0) begin
            if (last) begin
              emit      = 1'b1;
              kind      = gmi_pkg::RESULT_ERROR;
              phase_nxt = gmi_pkg::PH_STOP;
            end
          end else if (recent_nxt != gmi_pkg::MARK_END) begin
            emit      = 1'b1;
            kind      = gmi_pkg::RESULT_ERROR;
            phase_nxt = gmi_pkg::PH_STOP;
          end else begin
            emit       = 1'b1;
            mf_nxt     = mf_r + 16'd1;
            recent_nxt = '0;
            if (mf_nxt >= max_r || last) begin
              phase_nxt = gmi_pkg::PH_STOP;
            end else begin
              phase_nxt = gmi_pkg::PH_HUNT;
            end
          end
        end
        default: begin
          phase_nxt = gmi_pkg::PH_STOP;
        end
      endcase
    end
  end

  // result fields reflect the state as updated by this byte, index before the count moves
  always_comb begin
    res.vld                 = emit;
    res.data.result_kind    = kind;
    res.data.message_offset = gmi_pkg::OFFSET_W'(start_nxt);
    res.data.message_length = gmi_pkg::LENGTH_W'(len_nxt);
    res.data.edition        = ed_nxt;
    res.data.message_index  = mf_r;
  end

  assign stat.halted = (phase_r == gmi_pkg::PH_STOP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= gmi_pkg::PH_HUNT;
      pos_r    <= '0;
      recent_r <= '0;
      hidx_r   <= '0;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      ed_r     <= '0;
      start_r  <= '0;
      rem_r    <= '0;
      mf_r     <= '0;
      len_r    <= '0;
      max_r    <= gmi_pkg::MAX_MESSAGES_RST;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      recent_r <= recent_nxt;
      hidx_r   <= hidx_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
      ed_r     <= ed_nxt;
      start_r  <= start_nxt;
      rem_r    <= rem_nxt;
      mf_r     <= mf_nxt;
      len_r    <= len_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

endmodule

>>> rtl/grib_message_indexer.sv
`timescale 1ns / 1ps
// grib message indexer top level: input register, scanner and result register
// Usage:
//   in_valid/in_data/in_stall carry the file one byte per transfer, with
//   last_byte set on the final byte. out_valid/out_data/out_stall carry one
//   result per good message (offset, length, edition, index) or one error
//   result, after which the block halts and ignores further bytes.
//   cfg_wr_en/cfg_wr_data set the message limit; write it while idle.
//   A transferred byte is registered in the input register, scanned once the
//   result register is empty or being taken, and its result, if any, is
//   registered and presented on out_valid. One byte per cycle is
//   sustained while the result side is not stalled; the input register and
//   the result register are the only stages.
//   While out_stall holds a pending result, the scanner waits and in_stall
//   rises once the input register is full; nothing is dropped.
//   Synchronous active-low reset returns to the marker hunt at offset zero,
//   clears the message count and sets the limit to 65535.
module grib_message_indexer #(
  parameter int OFFSET_BITS = gmi_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = gmi_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  gmi_pkg::in_item_t  in_data,
  output logic               in_stall,
  output logic               out_valid,
  output gmi_pkg::out_item_t out_data,
  input  logic               out_stall,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  logic                s1_vld_r, s1_vld_nxt;
  gmi_pkg::in_item_t   s1_item_r;
  logic                out_vld_r, out_vld_nxt;
  gmi_pkg::out_item_t  out_item_r;
  logic                adv;
  logic                proc;
  gmi_pkg::scan_res_t  res;
  gmi_pkg::scan_stat_t stat;

  // the scanner may move only when the result slot is empty or being taken
  assign adv      = !out_vld_r || !out_stall;
  assign proc     = s1_vld_r && adv;
  assign in_stall = s1_vld_r && !adv;

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  always_comb begin
    if (in_valid && !in_stall) begin
      s1_vld_nxt = 1'b1;
    end else if (adv) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
    if (proc) begin
      out_vld_nxt = res.vld;
    end else begin
      out_vld_nxt = out_vld_r && out_stall;
    end
  end

  gmi_scan #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_vld    (proc),
    .item        (s1_item_r),
    .res         (res),
    .stat        (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (proc && res.vld) begin
      out_item_r <= res.data;
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with an empty input register");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && res.vld && res.data.result_kind == gmi_pkg::RESULT_ERROR) |=> stat.halted)
    else $error("scanner kept running after an error result");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stat.halted |=> stat.halted)
    else $error("scanner left the halted state without reset");

  a_no_result_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
    stat.halted |-> !res.vld)
    else $error("result produced while halted");
`endif

endmodule
